[sv/blr_pkg.sv]
// Shared types and constants for the line rasterizer core.
// No dependencies.
package blr_pkg;

  localparam logic [31:0] LINE_COLOUR = 32'h96FF8833;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // register select is paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int unsigned CFG_AW = 3;

  typedef struct packed {
    logic               command;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [9:0]  pixels_drawn;
  } out_item_t;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic step;
    logic rd_issue;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic walk_last;
  } dp_sts_t;

endpackage

[sv/bresenham_line_rasterizer_core.sv]
// Top level of the Bresenham line rasterizer with an internal RGBA frame store.
// Depends on blr_pkg, blr_ctrl, blr_dp (and blr_ram through blr_dp).
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  input    | start / busy           | in_item  (in_item_t)
//  result   | out_valid (1-cycle)    | out_item (out_item_t)
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata
//
// A draw loads the walk registers, steps the walk through each visited pixel and
// drains the address pipeline before the result; a read issues a single frame
// access and drains. The walk loop steps one pixel per cycle; the frame store has
// a single port. After reset a clearing pass writes every frame word, with busy
// high. Results are strobed for one cycle; the receiver cannot stall them.
module bresenham_line_rasterizer_core
  import blr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  output logic              out_valid,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [8:0] width_r, height_r, w_eff, h_eff;
  logic       cfg_wr;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        width_r <= pwdata[8:0];
      end else begin
        height_r <= pwdata[8:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? {23'd0, height_r} : {23'd0, width_r};

  assign w_eff = (13'(width_r) > 13'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_r;
  assign h_eff = (13'(height_r) > 13'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_r;

  blr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .command  (in_item.command),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy),
    .out_valid(out_valid)
  );

  blr_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_item (in_item),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .out_item(out_item)
  );

endmodule

[sv/blr_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module blr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[sv/blr_ctrl.sv]
// Controller FSM of the line rasterizer: clear sweep, walk, read, drain, result.
// Depends on blr_pkg.
module blr_ctrl
  import blr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    command,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy,
  output logic    out_valid
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_READ,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   drn_r, drn_nxt;
  logic   busy_r, out_valid_r;

  always_comb begin
    state_nxt = state_r;
    drn_nxt   = drn_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (command == CMD_READ) ? S_READ : S_WALK;
        end
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_DRAIN;
          drn_nxt   = 1'b0;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_DRAIN;
        drn_nxt      = 1'b0;
      end
      S_DRAIN: begin
        drn_nxt = 1'b1;
        if (drn_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      drn_r       <= 1'b0;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drn_r       <= drn_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      out_valid_r <= (state_nxt == S_DONE);
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("transaction accepted but core not busy");

  a_step_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.step && cmd.clr_en) && !(cmd.rd_issue && cmd.step))
    else $error("conflicting datapath commands");

endmodule

[sv/blr_dp.sv]
// Datapath of the line rasterizer: walk registers, address pipeline, frame store.
// Depends on blr_pkg and blr_ram.
module blr_dp
  import blr_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  input  in_item_t  in_item,
  input  logic [8:0] w_eff,
  input  logic [8:0] h_eff,
  output out_item_t out_item
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // walk state
  logic signed [15:0] wx_r, wx_nxt, wy_r, wy_nxt, x1_r, y1_r;
  logic signed [18:0] err_r, err_nxt, dx_r, dy_r;
  logic               sxn_r, syn_r, is_read_r;
  logic [9:0]         cnt_r;

  // pixel pipeline
  logic          p1_v_r, p1_wr_r, p2_v_r, p2_wr_r, hit_r;
  logic [8:0]    p1_x_r, p1_y_r;
  logic [AW-1:0] p2_addr_r, clr_addr_r;
  logic [18:0]   addr_full;

  // load terms
  logic signed [16:0] ddx, ddy;
  logic [16:0]        adx, ady;
  logic signed [18:0] ld_dx, ld_dy;

  // step terms
  logic               inb, xhit, yhit, c1, c2;
  logic signed [18:0] err1;
  logic signed [19:0] e2, e2b;

  logic        ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [31:0] ram_wdata, ram_rdata;

  assign ddx   = {in_item.end_x[15], in_item.end_x} - {in_item.start_x[15], in_item.start_x};
  assign ddy   = {in_item.end_y[15], in_item.end_y} - {in_item.start_y[15], in_item.start_y};
  assign adx   = ddx[16] ? 17'(-ddx) : 17'(ddx);
  assign ady   = ddy[16] ? 17'(-ddy) : 17'(ddy);
  assign ld_dx = $signed({2'b00, adx});
  assign ld_dy = -$signed({2'b00, ady});

  assign inb = !wx_r[15] && !wy_r[15] && ($unsigned(wx_r) < {7'd0, w_eff})
               && ($unsigned(wy_r) < {7'd0, h_eff});
  assign xhit = (wx_r == x1_r);
  assign yhit = (wy_r == y1_r);
  assign e2   = {err_r, 1'b0};
  assign c1   = (e2 >= $signed({dy_r[18], dy_r}));
  assign err1 = c1 ? err_r + dy_r : err_r;
  assign e2b  = {err1, 1'b0};
  assign c2   = (e2b <= $signed({dx_r[18], dx_r}));

  always_comb begin
    wx_nxt  = wx_r;
    wy_nxt  = wy_r;
    err_nxt = err_r;
    if (!(xhit && yhit) && !(c1 && xhit)) begin
      err_nxt = err1;
      if (c1) begin
        wx_nxt = sxn_r ? wx_r - 16'sd1 : wx_r + 16'sd1;
      end
      if (c2 && !yhit) begin
        err_nxt = err1 + dx_r;
        wy_nxt  = syn_r ? wy_r - 16'sd1 : wy_r + 16'sd1;
      end
    end
  end

  assign sts.walk_last = (xhit && yhit) || (c1 && xhit) || (c2 && yhit);
  assign sts.clr_last  = (clr_addr_r == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wx_r      <= in_item.start_x;
      wy_r      <= in_item.start_y;
      x1_r      <= in_item.end_x;
      y1_r      <= in_item.end_y;
      dx_r      <= ld_dx;
      dy_r      <= ld_dy;
      err_r     <= ld_dx + ld_dy;
      sxn_r     <= !(ddx > 17'sd0);
      syn_r     <= !(ddy > 17'sd0);
      is_read_r <= in_item.command;
      cnt_r     <= '0;
    end else if (cmd.step) begin
      wx_r  <= wx_nxt;
      wy_r  <= wy_nxt;
      err_r <= err_nxt;
      if (inb) begin
        cnt_r <= cnt_r + 10'd1;
      end
    end
  end

  assign addr_full = 19'({9'd0, p1_y_r} * {9'd0, w_eff}) + {10'd0, p1_x_r};

  always_ff @(posedge clk) begin
    p1_x_r    <= wx_r[8:0];
    p1_y_r    <= wy_r[8:0];
    p1_wr_r   <= cmd.step;
    p2_wr_r   <= p1_wr_r;
    p2_addr_r <= AW'(addr_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r     <= 1'b0;
      p2_v_r     <= 1'b0;
      hit_r      <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      p1_v_r <= (cmd.step || cmd.rd_issue) && inb;
      p2_v_r <= p1_v_r;
      hit_r  <= ram_re;
      if (cmd.clr_en) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  assign ram_we    = cmd.clr_en || (p2_v_r && p2_wr_r);
  assign ram_re    = p2_v_r && !p2_wr_r;
  assign ram_addr  = cmd.clr_en ? clr_addr_r : p2_addr_r;
  assign ram_wdata = cmd.clr_en ? 32'd0 : LINE_COLOUR;

  blr_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign out_item.read_data    = (is_read_r && hit_r) ? ram_rdata : 32'd0;
  assign out_item.pixels_drawn = is_read_r ? 10'd0 : cnt_r;

  a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_en && p2_v_r))
    else $error("pixel access during clear sweep");

endmodule
